// ===== rtl/ntcb_pkg.sv =====
// Shared constants and types for the NTC Beta-equation temperature converter.
// Used by ntcb_log2, ntcb_div and ntc_beta_temperature_converter_core.
package ntcb_pkg;

  localparam int ADC_BITS = 12;
  localparam logic [ADC_BITS-1:0] FS = {ADC_BITS{1'b1}};

  localparam int CFG_W  = 20;
  localparam int BETA_W = 14;

  // Products pullup*sample and nominal*(FS-sample).
  localparam int PROD_NW = CFG_W + ADC_BITS;

  // Base-2 logarithm in Q.24.
  localparam int LOG_FRAC = 24;
  localparam int EXP_W    = $clog2(PROD_NW);
  localparam int LOG_W    = EXP_W + LOG_FRAC;
  localparam int MANT_W   = 31;
  localparam int LOG_LAT  = LOG_FRAC + 1;

  localparam int DIFF_W = LOG_W + 1;
  localparam int LN2_W  = 17;
  localparam int PRODL_W = DIFF_W + LN2_W + 1;
  localparam logic [LN2_W-1:0] T0_LN2_Q8 = 17'd52905;

  localparam int DEN_W  = 48;
  localparam int NUM_W  = 33;
  localparam int DIV_SH = 32;
  localparam int Q_BITS = 20;
  localparam int DIV_LAT = Q_BITS + 1;
  localparam logic [18:0] T0_X1600 = 19'd477040;

  localparam logic [Q_BITS-1:0] Q_LOW  = 20'd373040;
  localparam logic [Q_BITS-1:0] Q_HIGH = 20'd637040;
  localparam logic [Q_BITS-1:0] ROUND_OFS = 20'd50;

  // floor(x/100) = (x * RECIP_100) >> RECIP_SH for x below 2^19.
  localparam int X_W      = 19;
  localparam int RECIP_W  = 21;
  localparam int RECIP_SH = 27;
  localparam int MUL_W    = X_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_100 = 21'd1342178;

  localparam int TEMP_W = 12;
  localparam logic [TEMP_W-1:0] T_OFS = 12'd640;

  localparam logic [CFG_W-1:0]  PULLUP_RST  = 20'd10000;
  localparam logic [BETA_W-1:0] BETA_RST    = 14'd3950;
  localparam logic [CFG_W-1:0]  NOMINAL_RST = 20'd10000;

  typedef enum logic [1:0] {
    CFG_PULLUP  = 2'd0,
    CFG_BETA    = 2'd1,
    CFG_NOMINAL = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/ntcb_log2.sv =====
// Pipelined base-2 logarithm in Q.24: one normalize stage, then one squaring
// stage per fraction bit. Depends on ntcb_pkg.
module ntcb_log2 (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ntcb_pkg::PROD_NW-1:0] v_i,
  output logic [ntcb_pkg::LOG_W-1:0]   log_o
);
  import ntcb_pkg::*;

  logic [EXP_W-1:0]    exp_d;
  logic [MANT_W-1:0]   mant_d;
  logic [63:0]         v_ext;
  logic [EXP_W-1:0]    exp_q  [LOG_LAT];
  logic [MANT_W-1:0]   mant_q [LOG_LAT];
  logic [LOG_FRAC-1:0] frac_q [LOG_LAT];

  assign v_ext = 64'(v_i);

  // Index of the leading one, then scale the value to Q1.30.
  always_comb begin
    exp_d = '0;
    for (int b = 0; b < PROD_NW; b++) begin
      if (v_i[b]) exp_d = EXP_W'(b);
    end
    if (exp_d <= EXP_W'(30)) begin
      mant_d = MANT_W'(v_ext << (6'd30 - 6'(exp_d)));
    end else begin
      mant_d = MANT_W'(v_ext >> (6'(exp_d) - 6'd30));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q[0]  <= exp_d;
      mant_q[0] <= mant_d;
      frac_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     top;

    assign sq  = mant_q[k] * mant_q[k];
    assign top = sq[2*MANT_W-1:30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        exp_q[k+1]  <= exp_q[k];
        mant_q[k+1] <= top[MANT_W] ? top[MANT_W:1] : top[MANT_W-1:0];
        frac_q[k+1] <= {frac_q[k][LOG_FRAC-2:0], top[MANT_W]};
      end
    end
  end

  assign log_o = {exp_q[LOG_LAT-1], frac_q[LOG_LAT-1]};

endmodule

// ===== rtl/ntcb_div.sv =====
// Pipelined restoring divider: floor(num * 2^32 / den) with an overflow flag
// for quotients of 2^20 and above. Depends on ntcb_pkg.
module ntcb_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ntcb_pkg::NUM_W-1:0]  num_i,
  input  logic [ntcb_pkg::DEN_W-2:0]  den_i,
  output logic [ntcb_pkg::Q_BITS-1:0] q_o,
  output logic                        ovf_o
);
  import ntcb_pkg::*;

  localparam int REM_W = NUM_W + DIV_SH;
  localparam int CMP_W = DEN_W - 1 + Q_BITS;

  logic [REM_W-1:0]  rem_d;
  logic [REM_W-1:0]  rem_q [DIV_LAT];
  logic [DEN_W-2:0]  den_q [DIV_LAT];
  logic [Q_BITS-1:0] quo_q [DIV_LAT];
  logic              ovf_q [DIV_LAT];

  assign rem_d = {num_i, DIV_SH'(0)};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= CMP_W'(rem_d) >= (CMP_W'(den_i) << Q_BITS);
    end
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    localparam int SH = Q_BITS - 1 - k;
    logic [CMP_W-1:0] trial;
    logic             ge;

    assign trial = CMP_W'(den_q[k]) << SH;
    assign ge    = CMP_W'(rem_q[k]) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? REM_W'(CMP_W'(rem_q[k]) - trial) : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_q[k] | (Q_BITS'(ge) << SH);
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign q_o   = quo_q[DIV_LAT-1];
  assign ovf_o = ovf_q[DIV_LAT-1];

endmodule

// ===== rtl/ntc_beta_temperature_converter_core.sv =====
// Top level of the NTC thermistor converter: sample to temperature in 1/16 C.
// Depends on ntcb_pkg, ntcb_log2 and ntcb_div.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+---------------------------------
//   config   | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//   sample   | in        | in_valid_i/in_ready_o | adc_sample_i
//   result   | out       | out_valid_o/out_ready_i | temp_sixteenths_o, reading_valid_o
//
// One request enters per cycle unless a result stall holds the pipeline; the path
// runs through the 25 stages of the log units and the 21 stages of the divider.
// Reset clears the valid bits and loads the default register values.
// A stall of the result freezes the whole pipeline; nothing is lost or repeated.
module ntc_beta_temperature_converter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [ntcb_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ntcb_pkg::ADC_BITS-1:0] adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [ntcb_pkg::TEMP_W-1:0] temp_sixteenths_o,
  output logic                          reading_valid_o
);
  import ntcb_pkg::*;

  logic [CFG_W-1:0]  pullup_q, nominal_q;
  logic [BETA_W-1:0] beta_q;
  logic              en;

  logic               vld1_q, bad1_q;
  logic [PROD_NW-1:0] n1_q, d1_q;
  logic [LOG_W-1:0]   log_n, log_d;
  logic               vldl_q [LOG_LAT];
  logic               badl_q [LOG_LAT];

  logic                       vld2_q, bad2_q;
  logic signed [DIFF_W-1:0]   diff2_q;
  logic                       vld3_q, bad3_q;
  logic signed [PRODL_W-1:0]  prod3_q;
  logic signed [DEN_W-1:0]    den_sum;
  logic                       vld4_q, bad4_q;
  logic [DEN_W-2:0]           den4_q;
  logic [NUM_W-1:0]           num4_q;

  logic [Q_BITS-1:0] quo;
  logic              ovf;
  logic              vldd_q [DIV_LAT];
  logic              badd_q [DIV_LAT];

  logic              vld5_q, bad5_q;
  logic [X_W-1:0]    x5_q;
  logic              vld6_q, bad6_q;
  logic [MUL_W-1:0]  prod6_q;
  logic              out_vld_q, out_ok_q;
  logic [TEMP_W-1:0] temp_q;
  logic [TEMP_W-1:0] temp_d;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pullup_q  <= PULLUP_RST;
      beta_q    <= BETA_RST;
      nominal_q <= NOMINAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PULLUP:  pullup_q  <= cfg_data_i;
        CFG_BETA:    beta_q    <= cfg_data_i[BETA_W-1:0];
        CFG_NOMINAL: nominal_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      vld6_q    <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < LOG_LAT; i++) vldl_q[i] <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) vldd_q[i] <= 1'b0;
    end else if (en) begin
      vld1_q    <= in_valid_i;
      vldl_q[0] <= vld1_q;
      for (int i = 1; i < LOG_LAT; i++) vldl_q[i] <= vldl_q[i-1];
      vld2_q    <= vldl_q[LOG_LAT-1];
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      vldd_q[0] <= vld4_q;
      for (int i = 1; i < DIV_LAT; i++) vldd_q[i] <= vldd_q[i-1];
      vld5_q    <= vldd_q[DIV_LAT-1];
      vld6_q    <= vld5_q;
      out_vld_q <= vld6_q;
    end
  end

  // Resistance products and the rail and zero-register checks.
  always_ff @(posedge clk_i) begin
    if (en) begin
      bad1_q <= (adc_sample_i == '0) || (adc_sample_i == FS) ||
                (pullup_q == '0) || (nominal_q == '0);
      n1_q   <= PROD_NW'(pullup_q) * PROD_NW'(adc_sample_i);
      d1_q   <= PROD_NW'(nominal_q) * PROD_NW'(FS - adc_sample_i);
    end
  end

  ntcb_log2 u_log_n (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (n1_q),
    .log_o (log_n)
  );

  ntcb_log2 u_log_d (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (d1_q),
    .log_o (log_d)
  );

  assign den_sum = $signed({2'b00, beta_q, DIV_SH'(0)}) + DEN_W'(prod3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      badl_q[0] <= bad1_q;
      for (int i = 1; i < LOG_LAT; i++) badl_q[i] <= badl_q[i-1];

      bad2_q  <= badl_q[LOG_LAT-1];
      diff2_q <= $signed({1'b0, log_n}) - $signed({1'b0, log_d});

      bad3_q  <= bad2_q;
      prod3_q <= diff2_q * $signed({1'b0, T0_LN2_Q8});

      // A denominator at or below zero has no physical temperature.
      bad4_q  <= bad3_q || (den_sum <= 0);
      den4_q  <= den_sum[DEN_W-2:0];
      num4_q  <= NUM_W'(T0_X1600) * NUM_W'(beta_q);
    end
  end

  ntcb_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num4_q),
    .den_i (den4_q),
    .q_o   (quo),
    .ovf_o (ovf)
  );

  assign temp_d = TEMP_W'(prod6_q[MUL_W-1:RECIP_SH]) - T_OFS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      badd_q[0] <= bad4_q;
      for (int i = 1; i < DIV_LAT; i++) badd_q[i] <= badd_q[i-1];

      // Keep only -40 C to 125 C, both ends included.
      bad5_q  <= badd_q[DIV_LAT-1] || ovf || (quo < Q_LOW) || (quo > Q_HIGH);
      x5_q    <= X_W'(quo - Q_LOW + ROUND_OFS);

      bad6_q  <= bad5_q;
      prod6_q <= MUL_W'(x5_q) * MUL_W'(RECIP_100);

      out_ok_q <= !bad6_q;
      temp_q   <= bad6_q ? '0 : temp_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign reading_valid_o   = out_ok_q;
  assign temp_sixteenths_o = $signed(temp_q);

endmodule

// ===== test/tb_ntc_beta_temperature_converter_core.sv =====
// Self-checking testbench for ntc_beta_temperature_converter_core.
// Depends on ntcb_pkg; predicts each reading in integer math and checks every result in order.
`timescale 1ns / 100ps

module tb_ntc_beta_temperature_converter_core;
  import ntcb_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     ok;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ADC_BITS-1:0] adc_sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [TEMP_W-1:0] temp_sixteenths_o;
  logic reading_valid_o;

  ntc_beta_temperature_converter_core u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copies of the registers.
  logic [CFG_W-1:0]  pullup_r  = PULLUP_RST;
  logic [BETA_W-1:0] beta_r    = BETA_RST;
  logic [CFG_W-1:0]  nominal_r = NOMINAL_RST;

  logic [ADC_BITS-1:0] sample_q[$];
  reading_t            reading_q[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int n_fail = 0;
  int n_checked = 0;
  int n_valid = 0;
  logic took = 1'b0;

  function automatic longint log2_q24(input longint unsigned v);
    int e;
    longint unsigned m;
    longint frac;
    e = 0;
    frac = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    if (e <= 30) m = v << (30 - e);
    else m = v >> (e - 30);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(e) << LOG_FRAC) + frac;
  endfunction

  function automatic reading_t convert_sample(input logic [ADC_BITS-1:0] s);
    reading_t res;
    longint unsigned n, d, num, uden, q, r;
    longint diff, den, c, t;
    res = '0;
    if (s == 0 || s == FS || pullup_r == 0 || nominal_r == 0) return res;
    n = longint'(pullup_r) * longint'(s);
    d = longint'(nominal_r) * longint'(FS - s);
    diff = log2_q24(n) - log2_q24(d);
    den = (longint'(beta_r) << 32) + 64'sd52905 * diff;
    if (den <= 0) return res;
    uden = den;
    num = 64'd477040 * longint'(beta_r);
    q = num / uden;
    r = num % uden;
    if (q >= (64'd1 << 20)) return res;
    for (int i = 0; i < 32; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= uden) begin
        r = r - uden;
        q = q | 1;
      end
    end
    if (q > 64'd637040) return res;
    c = longint'(q) - 437040;
    if (c < -64000) return res;
    t = (c + 64000 + 50) / 100 - 640;
    res.temp = t[TEMP_W-1:0];
    res.ok = 1'b1;
    return res;
  endfunction

  // Request driver.
  always @(posedge clk_i) took <= in_valid_i && in_ready_o;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took)) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        adc_sample_i <= sample_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Prediction on acceptance, checking on each result.
  always @(posedge clk_i) begin
    reading_t exp_r;
    if (in_valid_i && in_ready_o) reading_q.push_back(convert_sample(adc_sample_i));
    if (out_valid_o && out_ready_i) begin
      if (reading_q.size() == 0) begin
        $error("result with no pending request: temp %0d valid %0b",
               temp_sixteenths_o, reading_valid_o);
        n_fail++;
      end else begin
        exp_r = reading_q.pop_front();
        n_checked++;
        if (exp_r.ok) n_valid++;
        if (temp_sixteenths_o !== exp_r.temp) begin
          $error("temp_sixteenths: expected %0d, got %0d", exp_r.temp, temp_sixteenths_o);
          n_fail++;
        end
        if (reading_valid_o !== exp_r.ok) begin
          $error("reading_valid: expected %0b, got %0b", exp_r.ok, reading_valid_o);
          n_fail++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_PULLUP:  pullup_r = val;
      CFG_BETA:    beta_r = val[BETA_W-1:0];
      CFG_NOMINAL: nominal_r = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_q.size() > 0 || in_valid_i || reading_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: ;  // reset values
        1: write_reg(CFG_PULLUP, '0);
        2: begin
          write_reg(CFG_PULLUP, 20'd10000);
          write_reg(CFG_NOMINAL, '0);
        end
        3: begin
          write_reg(CFG_NOMINAL, 20'd10000);
          write_reg(CFG_BETA, '0);
        end
        4: begin
          write_reg(CFG_PULLUP, 20'd1000000);
          write_reg(CFG_BETA, 20'hFFFFF);
          write_reg(CFG_NOMINAL, 20'd1);
        end
        5: begin
          write_reg(CFG_PULLUP, 20'd1);
          write_reg(CFG_BETA, 20'd1000);
          write_reg(CFG_NOMINAL, 20'hFFFFF);
        end
        6: begin
          write_reg(CFG_PULLUP, 20'd10000);
          write_reg(CFG_BETA, 20'd10000);
          write_reg(CFG_NOMINAL, 20'd1000000);
          // Index three maps to no register and must change nothing.
          write_reg(CFG_UNUSED, 20'd12345);
        end
        default: begin
          write_reg(CFG_PULLUP, 20'($urandom_range(100000, 1000)));
          write_reg(CFG_BETA, 20'($urandom_range(4500, 3000)));
          write_reg(CFG_NOMINAL, 20'($urandom_range(100000, 1000)));
        end
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      if (p < 7) begin
        sample_q.push_back('0);
        sample_q.push_back(12'd1);
        sample_q.push_back(12'd2);
        sample_q.push_back(12'd2048);
        sample_q.push_back(FS - 12'd1);
        sample_q.push_back(FS);
        sample_q.push_back(12'hAAA);
        sample_q.push_back(12'h555);
      end
      repeat (p < 7 ? 20 : 90) sample_q.push_back(ADC_BITS'($urandom));
      wait_drained();
    end
    $display("Checked %0d readings (%0d in range) over 12 register settings and four",
             n_checked, n_valid);
    $display("flow-control patterns, including zero resistors and rail samples.");
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ntcb_pkg.sv
rtl/ntcb_log2.sv
rtl/ntcb_div.sv
rtl/ntc_beta_temperature_converter_core.sv
test/tb_ntc_beta_temperature_converter_core.sv
